/* sv/button_debounce_repeat_hold_macros.svh */
`ifndef BUTTON_DEBOUNCE_REPEAT_HOLD_MACROS_SVH
`define BUTTON_DEBOUNCE_REPEAT_HOLD_MACROS_SVH

// same-cycle implication, skipped during reset
`define BDRH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, skipped during reset
`define BDRH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bdrh_pkg.sv */
package bdrh_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CFG_W = 16;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd0;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_REPEAT   = 1'b1
   } csr_index_type;

   // input item, highest bit first
   typedef struct packed {
      logic fake_toggle;
      logic fake_press;
      logic disable_request;
      logic clear_pressed;
      logic query_pressed;
      logic pin_low;
   } req_item_type;

   // result item, highest bit first
   typedef struct packed {
      logic              press_latched;
      logic [TIME_W-1:0] held_ms;
      logic              press_report;
   } rsp_item_type;

   localparam int unsigned REQ_BITS = $bits(req_item_type);
   localparam int unsigned RSP_BITS = $bits(rsp_item_type);
   localparam int unsigned REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

endpackage

/* sv/button_debounce_repeat_hold.sv */
// channel | direction | payload
// req     | in        | pin_low, query_pressed, clear_pressed, disable_request,
//         |           | fake_press, fake_toggle (tdata bits 0..5)
// rsp     | out       | press_report, held_ms, press_latched (tdata bits 0, 32:1, 33)
// csr     | in        | write enable, index 0 debounce_ms / 1 repeat_ms, 16-bit data
//
// one item per clock sustained while the rsp side is not stalled; an item is held in
// the input register, then its result is formed by one pass of compare and subtract
// logic into the result register, which drives rsp_tvalid
// reset is synchronous: clears the time counter, stored times and flags, and
// loads debounce_ms with 20 and repeat_ms with 0
// a stalled rsp side holds the result; the input register still takes one more item
`include "button_debounce_repeat_hold_macros.svh"

module button_debounce_repeat_hold
   import bdrh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // pin_low, query_pressed, clear_pressed, disable_request, fake_press, fake_toggle
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // press_report, held_ms[31:0], press_latched
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   logic [CFG_W-1:0]  debounce_ff;
   logic [CFG_W-1:0]  repeat_ff;

   logic              in_valid_ff;
   req_item_type      in_ff;
   logic              out_valid_ff;
   rsp_item_type      out_ff;

   logic [TIME_W-1:0] ms_ff, ms_in;
   logic [TIME_W-1:0] press_ff, press_in;
   logic [TIME_W-1:0] release_ff, release_in;
   logic              latch_ff, latch_in;
   logic              prev_ff, prev_in;
   logic              sup_ff, sup_in;
   logic              tog_ff, tog_in;
   rsp_item_type      res;

   logic              advance;
   logic [TIME_W-1:0] d_release;
   logic [TIME_W-1:0] d_press;
   logic [TIME_W-1:0] d_press_eff;
   logic              press_upd;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, out_ff};

   assign ms_in     = ms_ff + 1'b1;
   assign d_release = ms_in - release_ff;
   assign d_press   = ms_in - press_ff;

   always_comb begin
      prev_in     = prev_ff;
      latch_in    = latch_ff;
      release_in  = release_ff;
      tog_in      = tog_ff;
      press_upd   = 1'b0;
      res         = '0;
      d_press_eff = d_press;

      // edge detection
      if (in_ff.pin_low != prev_ff) begin
         prev_in = in_ff.pin_low;
         if (in_ff.pin_low) begin
            if (d_release >= {{(TIME_W - CFG_W){1'b0}}, debounce_ff} &&
                d_press >= {{(TIME_W - CFG_W){1'b0}}, debounce_ff}) begin
               latch_in  = 1'b1;
               press_upd = 1'b1;
            end
         end else begin
            release_in = ms_in;
         end
      end

      // requests
      sup_in = sup_ff || in_ff.disable_request;
      if (in_ff.fake_press) begin
         latch_in = 1'b1;
      end
      if (in_ff.fake_toggle) begin
         tog_in = !tog_ff;
         if (!tog_ff) begin
            latch_in  = 1'b1;
            press_upd = 1'b1;
         end
      end
      if (sup_in && !in_ff.pin_low) begin
         sup_in = 1'b0;
      end

      // press time moved to now gives a zero difference
      if (press_upd) begin
         d_press_eff = '0;
      end

      // query
      if (in_ff.query_pressed) begin
         if (sup_in) begin
            latch_in = 1'b0;
         end else begin
            res.press_report = latch_in;
            if (repeat_ff != '0 && !latch_in && in_ff.pin_low &&
                d_press_eff >= {{(TIME_W - CFG_W){1'b0}}, repeat_ff}) begin
               res.press_report = 1'b1;
               press_upd        = 1'b1;
               d_press_eff      = '0;
            end
            if (in_ff.clear_pressed) begin
               latch_in = 1'b0;
            end
         end
      end

      // held time
      if (!sup_in && (in_ff.pin_low || tog_in)) begin
         res.held_ms = (d_press_eff == '0) ? {{(TIME_W - 1){1'b0}}, 1'b1} : d_press_eff;
      end
      res.press_latched = latch_in;

      press_in = press_upd ? ms_in : press_ff;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= req_tdata[REQ_BITS-1:0];
      end
      if (advance) begin
         out_ff <= res;
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         debounce_ff  <= DEBOUNCE_RESET;
         repeat_ff    <= REPEAT_RESET;
         ms_ff        <= '0;
         press_ff     <= '0;
         release_ff   <= '0;
         latch_ff     <= 1'b0;
         prev_ff      <= 1'b0;
         sup_ff       <= 1'b0;
         tog_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               CSR_REPEAT:   repeat_ff   <= csr_wdata;
               default:      ;
            endcase
         end
         if (advance) begin
            ms_ff      <= ms_in;
            press_ff   <= press_in;
            release_ff <= release_in;
            latch_ff   <= latch_in;
            prev_ff    <= prev_in;
            sup_ff     <= sup_in;
            tog_ff     <= tog_in;
         end
      end
   end

   `BDRH_ASSERT_NEXT(a_tick_advance, clock, reset, advance, ms_ff == $past(ms_ff) + 1'b1, "tick counter did not advance with item")
   `BDRH_ASSERT_NEXT(a_tick_hold, clock, reset, !advance, $stable(ms_ff) && $stable(press_ff) && $stable(latch_ff), "state moved without an item")
   `BDRH_ASSERT_NEXT(a_report_needs_query, clock, reset, advance && !in_ff.query_pressed, !out_ff.press_report, "report without a query")
   `BDRH_ASSERT_NEXT(a_fake_press_latch, clock, reset, advance && in_ff.fake_press && !in_ff.query_pressed, out_ff.press_latched && latch_ff, "fake press did not set latch")
   `BDRH_ASSERT_NOW(a_released_unsuppressed, clock, reset, !prev_ff, !sup_ff, "suppression kept while released")

endmodule

/* tb/button_debounce_repeat_hold_tb.sv */
`timescale 1ns / 1ps

module button_debounce_repeat_hold_tb;
   import bdrh_pkg::*;

   localparam int unsigned PHASE_ITEMS = 230;
   localparam int unsigned NUM_PHASES = 6;
   localparam int unsigned TUNE_ROW = 9;
   localparam int unsigned SQUEEZE_CYCLES = 64;
   localparam int unsigned TAIL_CYCLES = 8;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type want;
   } tick_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_DEBOUNCE;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // predictor copy of the configuration and state
   logic [CFG_W-1:0]  cfg_debounce = DEBOUNCE_RESET;
   logic [CFG_W-1:0]  cfg_repeat = REPEAT_RESET;
   logic [TIME_W-1:0] ms_now = '0;
   logic [TIME_W-1:0] pressed_at = '0;
   logic [TIME_W-1:0] released_at = '0;
   logic              latch_q = 1'b0;
   logic              pin_prev = 1'b0;
   logic              muted = 1'b0;
   logic              toggle_on = 1'b0;

   rsp_item_type answer_q[$];
   int unsigned  mismatches = 0;
   bit           calm = 1'b0;
   bit           squeeze_req = 1'b0;

   button_debounce_repeat_hold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic req_item_type pack_tick(bit pin, bit query, bit clr, bit dis, bit fp,
                                              bit ft);
      req_item_type it;
      it.pin_low = pin;
      it.query_pressed = query;
      it.clear_pressed = clr;
      it.disable_request = dis;
      it.fake_press = fp;
      it.fake_toggle = ft;
      return it;
   endfunction

   function automatic rsp_item_type pack_answer(bit report, logic [TIME_W-1:0] held,
                                                bit latched);
      rsp_item_type r;
      r.press_report = report;
      r.held_ms = held;
      r.press_latched = latched;
      return r;
   endfunction

   // one millisecond tick of the debouncer
   function automatic rsp_item_type advance_tick(req_item_type it);
      rsp_item_type      r;
      logic [TIME_W-1:0] since_release;
      logic [TIME_W-1:0] since_press;
      r = '0;
      ms_now = ms_now + 1;
      since_release = ms_now - released_at;
      since_press = ms_now - pressed_at;
      if (it.pin_low != pin_prev) begin
         pin_prev = it.pin_low;
         if (it.pin_low) begin
            if (since_release >= TIME_W'(cfg_debounce) && since_press >= TIME_W'(cfg_debounce)) begin
               latch_q = 1'b1;
               pressed_at = ms_now;
            end
         end else begin
            released_at = ms_now;
         end
      end
      if (it.disable_request)
         muted = 1'b1;
      if (it.fake_press)
         latch_q = 1'b1;
      if (it.fake_toggle) begin
         toggle_on = ~toggle_on;
         if (toggle_on) begin
            latch_q = 1'b1;
            pressed_at = ms_now;
         end
      end
      if (muted && !it.pin_low)
         muted = 1'b0;
      if (it.query_pressed) begin
         if (muted) begin
            latch_q = 1'b0;
         end else begin
            r.press_report = latch_q;
            since_press = ms_now - pressed_at;
            if (cfg_repeat != 0 && !latch_q && it.pin_low &&
                since_press >= TIME_W'(cfg_repeat)) begin
               r.press_report = 1'b1;
               pressed_at = ms_now;
            end
            if (it.clear_pressed)
               latch_q = 1'b0;
         end
      end
      if (!muted && (it.pin_low || toggle_on)) begin
         r.held_ms = ms_now - pressed_at;
         if (r.held_ms == 0)
            r.held_ms = 1;
      end
      r.press_latched = latch_q;
      return r;
   endfunction

   task automatic send_tick(req_item_type it, bit typed, rsp_item_type want);
      rsp_item_type guess;
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, it};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      guess = advance_tick(it);
      answer_q.push_back(typed ? want : guess);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] rep);
      csr_we <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= CSR_REPEAT;
      csr_wdata <= rep;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_debounce = deb;
      cfg_repeat = rep;
   endtask

   task automatic note_failure(string what, rsp_item_type want, rsp_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: exp report=%0d held=%0d latched=%0d, got report=%0d held=%0d latched=%0d",
                  what, want.press_report, want.held_ms, want.press_latched,
                  got.press_report, got.held_ms, got.press_latched);
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (answer_q.size() == 0) begin
            note_failure("unexpected item", '0, got);
         end else begin
            want = answer_q.pop_front();
            if (got.press_report !== want.press_report || got.held_ms !== want.held_ms ||
                got.press_latched !== want.press_latched)
               note_failure("mismatch", want, got);
         end
      end
   end

   // result side: random stalls, one long hold-off, none at the end
   initial begin : rsp_side
      bit squeezed;
      squeezed = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (squeeze_req && !squeezed) begin
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      tick_row_type     rows[$];
      logic [CFG_W-1:0] deb_set[NUM_PHASES];
      logic [CFG_W-1:0] rep_set[NUM_PHASES];
      int unsigned      sent;
      int unsigned      up_len;
      int unsigned      down_len;
      bit               level;

      // reset settings first, then debounce 2 and repeat 3 from TUNE_ROW on
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 0), 1'b1, pack_answer(0, 0, 0)});
      rows.push_back('{pack_tick(0, 1, 0, 0, 1, 0), 1'b1, pack_answer(1, 0, 1)});
      rows.push_back('{pack_tick(0, 1, 1, 0, 0, 0), 1'b1, pack_answer(1, 0, 0)});
      // clear without query
      rows.push_back('{pack_tick(0, 0, 1, 0, 0, 0), 1'b1, pack_answer(0, 0, 0)});
      // disable while released
      rows.push_back('{pack_tick(0, 0, 0, 1, 0, 0), 1'b1, pack_answer(0, 0, 0)});
      // simulated hold on, zero difference
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 1), 1'b1, pack_answer(0, 1, 1)});
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 1), 1'b0, '0});
      // press too early after reset
      rows.push_back('{pack_tick(1, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 1, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(1, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(1, 1, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(1, 1, 1, 0, 0, 0), 1'b0, '0});
      // auto-repeat fires
      rows.push_back('{pack_tick(1, 1, 0, 0, 0, 0), 1'b0, '0});
      // suppressed query and suppressed hold
      rows.push_back('{pack_tick(1, 1, 0, 1, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(1, 1, 1, 0, 1, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 1, 0, 0, 0, 0), 1'b0, '0});
      // bounce inside debounce window
      rows.push_back('{pack_tick(1, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(0, 0, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back('{pack_tick(1, 1, 1, 0, 1, 1), 1'b0, '0});
      rows.push_back('{pack_tick(1, 1, 1, 1, 1, 1), 1'b0, '0});

      deb_set = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'($urandom_range(0, 15)), 16'd8};
      rep_set = '{16'd0, 16'd65535, 16'd5, 16'd1, 16'($urandom_range(0, 12)), 16'd0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < rows.size(); i++) begin
         if (i == TUNE_ROW) begin
            req_tvalid <= 1'b0;
            wait_drained();
            write_settings(16'd2, 16'd3);
         end
         send_tick(rows[i].item, rows[i].typed, rows[i].want);
      end

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         write_settings(deb_set[p], rep_set[p]);
         if (p == NUM_PHASES - 1)
            calm = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (p == 2 && sent >= 40)
               squeeze_req = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
               send_tick(req_item_type'(REQ_BITS'($urandom_range(0, 63))), 1'b0, '0);
               sent++;
            end else begin
               // a release stretch, then a hold stretch, with sparse requests
               down_len = $urandom_range(1, 12);
               up_len = $urandom_range(1, 24);
               for (int unsigned k = 0; k < down_len + up_len; k++) begin
                  level = (k >= down_len);
                  send_tick(pack_tick(level, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 40) == 0, $urandom_range(0, 30) == 0,
                                      $urandom_range(0, 40) == 0), 1'b0, '0);
                  sent++;
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("button_debounce_repeat_hold_tb: PASS");
      else
         $display("button_debounce_repeat_hold_tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("button_debounce_repeat_hold_tb: FAIL");
      $finish;
   end

endmodule
